/* rtl/lad_pkg.sv */
// ---------------------------------------------------------------------------
// lad_pkg - shared definitions for the linear array deque
// Operation and status codes, field widths and the default depth.
// ---------------------------------------------------------------------------
package lad_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = 4;
    localparam int OP_W      = 2;
    localparam int ST_W      = 2;
    localparam int OUT_W     = 40;

    typedef enum logic [OP_W-1:0] {
        OP_INS_REAR  = 2'd0,
        OP_INS_FRONT = 2'd1,
        OP_DEL_FRONT = 2'd2,
        OP_DEL_REAR  = 2'd3
    } lad_op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK            = 2'd0,
        ST_FULL          = 2'd1,
        ST_FRONT_REFUSED = 2'd2,
        ST_EMPTY         = 2'd3
    } lad_status_t;

    // Slot store strobes from the index controller
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } lad_mem_ctl_t;

endpackage

/* rtl/lad_ctrl.sv */
// ---------------------------------------------------------------------------
// lad_ctrl - index controller
// Holds front/rear indices and the empty mark, decodes one operation per
// transaction into slot strobes, status and the post-operation count/flags.
// ---------------------------------------------------------------------------
module lad_ctrl #(
    parameter int DEPTH = lad_pkg::DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  lad_pkg::lad_op_t            op,
    output lad_pkg::lad_mem_ctl_t       mem_ctl,
    output logic [IDX_W-1:0]            wr_addr,
    output logic [IDX_W-1:0]            rd_addr,
    output lad_pkg::lad_status_t        status,
    output logic [lad_pkg::CNT_W-1:0]   count,
    output logic                        is_empty,
    output logic                        is_full
);
    import lad_pkg::*;

    localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic             empty_reg, empty_next;
    logic             full_now;
    logic [IDX_W:0]   cnt_wide;

    assign full_now = !empty_reg && (tail_reg == LAST);

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        empty_next = empty_reg;
        mem_ctl    = '0;
        wr_addr    = '0;
        rd_addr    = head_reg;
        status     = ST_OK;
        case (op)
            OP_INS_REAR: begin
                if (full_now) begin
                    status = ST_FULL;
                end else if (empty_reg) begin
                    head_next      = '0;
                    tail_next      = '0;
                    empty_next     = 1'b0;
                    mem_ctl.wr_en  = 1'b1;
                    wr_addr        = '0;
                end else begin
                    tail_next      = tail_reg + 1'b1;
                    mem_ctl.wr_en  = 1'b1;
                    wr_addr        = tail_reg + 1'b1;
                end
            end
            OP_INS_FRONT: begin
                if (full_now || empty_reg || head_reg == '0) begin
                    status = ST_FRONT_REFUSED;
                end else begin
                    head_next      = head_reg - 1'b1;
                    mem_ctl.wr_en  = 1'b1;
                    wr_addr        = head_reg - 1'b1;
                end
            end
            OP_DEL_FRONT: begin
                rd_addr = head_reg;
                if (empty_reg) begin
                    status = ST_EMPTY;
                end else begin
                    mem_ctl.rd_en = 1'b1;
                    if (head_reg == tail_reg) begin
                        head_next  = '0;
                        tail_next  = '0;
                        empty_next = 1'b1;
                    end else begin
                        head_next = head_reg + 1'b1;
                    end
                end
            end
            OP_DEL_REAR: begin
                rd_addr = tail_reg;
                if (empty_reg) begin
                    status = ST_EMPTY;
                end else begin
                    mem_ctl.rd_en = 1'b1;
                    if (head_reg == tail_reg) begin
                        head_next  = '0;
                        tail_next  = '0;
                        empty_next = 1'b1;
                    end else begin
                        tail_next = tail_reg - 1'b1;
                    end
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
        if (!accept) begin
            mem_ctl = '0;
        end
    end

    // Flags and count describe the state after this operation
    assign cnt_wide = empty_next ? '0
                    : ({1'b0, tail_next} - {1'b0, head_next} + 1'b1);
    assign count    = CNT_W'(cnt_wide);
    assign is_empty = empty_next;
    assign is_full  = !empty_next && (tail_next == LAST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
        end else if (accept) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
        end
    end

endmodule

/* rtl/lad_store.sv */
// ---------------------------------------------------------------------------
// lad_store - slot memory
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module lad_store #(
    parameter int DEPTH = lad_pkg::DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                         aclk,
    input  lad_pkg::lad_mem_ctl_t        mem_ctl,
    input  logic [IDX_W-1:0]             wr_addr,
    input  logic [lad_pkg::DATA_W-1:0]   wr_data,
    input  logic [IDX_W-1:0]             rd_addr,
    output logic [lad_pkg::DATA_W-1:0]   rd_data
);
    import lad_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_ctl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/linear_array_deque.sv */
// ---------------------------------------------------------------------------
// linear_array_deque - double-ended queue in a fixed, non-circular array
// Insert/remove at either end, one result transaction per input transaction.
// ---------------------------------------------------------------------------
// Each input transaction carries an operation in s_tuser and a value in
// s_tdata; exactly one result transaction follows with the removed value,
// status, count and empty/full flags. The block takes one transaction per
// cycle, stalling input only while a held result is not taken, and the
// result appears in the cycle after acceptance: the indices update at the
// accepting edge and the slot memory's registered read port delivers the
// removed entry with the rest of the result register. The array does not
// wrap: the rear grows only up to slot DEPTH-1 and the front only into
// slots freed by front removals. No clearing pass is needed after reset.
module linear_array_deque #(
    parameter int DEPTH = lad_pkg::DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lad_pkg::DATA_W-1:0]    s_tdata,  // [31:0] value
    input  logic [lad_pkg::OP_W-1:0]      s_tuser,  // [1:0] operation
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] removed_value, [33:32] status, [37:34] count,
    // [38] is_empty, [39] is_full
    output logic [lad_pkg::OUT_W-1:0]     m_tdata
);
    import lad_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);

    logic             accept;
    lad_op_t          op;
    lad_mem_ctl_t     mem_ctl;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    lad_status_t      status;
    logic [CNT_W-1:0] count;
    logic             is_empty;
    logic             is_full;
    logic [DATA_W-1:0] rd_data;

    logic             m_tvalid_reg;
    logic             rm_ok_reg;
    lad_status_t      status_reg;
    logic [CNT_W-1:0] count_reg;
    logic             empty_reg;
    logic             full_reg;
    logic [DATA_W-1:0] removed_value;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign op       = lad_op_t'(s_tuser);

    lad_ctrl #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .op       (op),
        .mem_ctl  (mem_ctl),
        .wr_addr  (wr_addr),
        .rd_addr  (rd_addr),
        .status   (status),
        .count    (count),
        .is_empty (is_empty),
        .is_full  (is_full)
    );

    lad_store #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .mem_ctl (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (s_tdata),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rm_ok_reg  <= mem_ctl.rd_en;
            status_reg <= status;
            count_reg  <= count;
            empty_reg  <= is_empty;
            full_reg   <= is_full;
        end
    end

    // Zero the removed value unless a removal succeeded
    assign removed_value = rm_ok_reg ? rd_data : '0;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {full_reg, empty_reg, count_reg, status_reg, removed_value};

`ifndef SYNTHESIS
    a_flags_exclusive : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[38] && m_tdata[39]))
        else $error("deque reports empty and full together");

    a_empty_zero_value : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[33:32] == ST_EMPTY) |-> (m_tdata[31:0] == '0 && m_tdata[38]))
        else $error("empty removal returned data or left entries");

    a_empty_count : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[38]) |-> (m_tdata[37:34] == '0))
        else $error("empty deque reports nonzero count");

    a_full_refusal : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[33:32] == ST_FULL) |-> m_tdata[39])
        else $error("rear refusal while not full");
`endif

endmodule

/* test/linear_array_deque_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// linear_array_deque_tb - self-checking bench for the linear array deque
// Drives operation/value transactions and keeps a shadow copy of the slots,
// indices and empty flag to predict each result. Every result is checked as
// a whole, in order, against the oldest pending prediction. Both stream
// sides stall at random, with one long stretch without stalls.
// ---------------------------------------------------------------------------
module linear_array_deque_tb;
    import lad_pkg::*;

    localparam int SLOTS      = DEPTH_DEF;
    localparam int RAND_ITEMS = 1320;

    // packed from the top bit down, matching m_tdata
    typedef struct packed {
        logic              is_full;
        logic              is_empty;
        logic [CNT_W-1:0]  count;
        lad_status_t       status;
        logic [DATA_W-1:0] removed;
    } deque_result_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;   // [31:0] value
    logic [OP_W-1:0]   s_tuser = '0;   // [1:0] operation
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // [31:0] removed_value, [33:32] status, [37:34] count,
    // [38] is_empty, [39] is_full
    logic [OUT_W-1:0]  m_tdata;

    // shadow state of the deque
    logic [DATA_W-1:0] shadow_slots [SLOTS];
    int                head_idx = 0;
    int                tail_idx = 0;
    logic              shadow_empty = 1'b1;

    deque_result_t     pending_results [$];
    int                mismatch_count = 0;
    bit                steady = 1'b0;

    linear_array_deque #(.DEPTH(SLOTS)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2ms;
        $display("end of test: mismatches");
        $finish;
    end

    // Advance the shadow deque by one operation and queue its result.
    task automatic apply_deque_op(input lad_op_t op, input logic [DATA_W-1:0] val);
        deque_result_t r;
        logic          full_now;
        r = '0;
        r.status = ST_OK;
        full_now = !shadow_empty && tail_idx == SLOTS - 1;
        case (op)
            OP_INS_REAR: begin
                if (full_now) begin
                    r.status = ST_FULL;
                end else if (shadow_empty) begin
                    head_idx = 0;
                    tail_idx = 0;
                    shadow_empty = 1'b0;
                    shadow_slots[0] = val;
                end else begin
                    tail_idx++;
                    shadow_slots[tail_idx] = val;
                end
            end
            OP_INS_FRONT: begin
                if (full_now || shadow_empty || head_idx == 0) begin
                    r.status = ST_FRONT_REFUSED;
                end else begin
                    head_idx--;
                    shadow_slots[head_idx] = val;
                end
            end
            OP_DEL_FRONT: begin
                if (shadow_empty) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.removed = shadow_slots[head_idx];
                    if (head_idx == tail_idx) begin
                        head_idx = 0;
                        tail_idx = 0;
                        shadow_empty = 1'b1;
                    end else begin
                        head_idx++;
                    end
                end
            end
            default: begin
                if (shadow_empty) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.removed = shadow_slots[tail_idx];
                    if (head_idx == tail_idx) begin
                        head_idx = 0;
                        tail_idx = 0;
                        shadow_empty = 1'b1;
                    end else begin
                        tail_idx--;
                    end
                end
            end
        endcase
        r.count    = shadow_empty ? '0 : CNT_W'(tail_idx - head_idx + 1);
        r.is_empty = shadow_empty;
        r.is_full  = !shadow_empty && tail_idx == SLOTS - 1;
        pending_results.push_back(r);
    endtask

    // Send one transaction; predict its result once it is accepted.
    task automatic push_op(input lad_op_t op, input logic [DATA_W-1:0] val);
        @(negedge aclk);
        if (!steady) begin
            while ($urandom_range(99) < 23) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= val;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        apply_deque_op(op, val);
    endtask

    always @(negedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= steady || ($urandom_range(99) >= 23);
    end

    always @(posedge aclk) begin
        deque_result_t got;
        deque_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = deque_result_t'(m_tdata);
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%t: result transaction with nothing pending: %h", $realtime,
                             m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%t: exp %h/%0d/%0d/%b/%b got %h/%0d/%0d/%b/%b",
                                 $realtime, want.removed, want.status, want.count,
                                 want.is_empty, want.is_full, got.removed, got.status,
                                 got.count, got.is_empty, got.is_full);
                end
            end
        end
    end

    task automatic test_empty_cases();
        push_op(OP_DEL_FRONT, 32'h1111_1111);
        push_op(OP_DEL_REAR, 32'hFFFF_FFFF);
        push_op(OP_INS_FRONT, 32'h0BAD_F00D);
        push_op(OP_INS_REAR, 32'h8000_0000);
        // head sits at slot zero: front insert is refused
        push_op(OP_INS_FRONT, 32'h2222_2222);
    endtask

    task automatic test_fill_to_full();
        push_op(OP_INS_REAR, 32'h7FFF_FFFF);
        push_op(OP_INS_REAR, 32'hFFFF_FFFF);
        push_op(OP_INS_REAR, 32'h0000_0000);
        push_op(OP_INS_REAR, 32'h0000_0001);
        push_op(OP_INS_REAR, 32'h5555_5555);
        push_op(OP_INS_REAR, 32'hAAAA_AAAA);
        push_op(OP_INS_REAR, 32'h1234_5678);
        push_op(OP_INS_REAR, 32'h3333_3333);
        push_op(OP_INS_FRONT, 32'h4444_4444);
    endtask

    task automatic test_front_regrow();
        push_op(OP_DEL_FRONT, '0);
        push_op(OP_DEL_FRONT, '0);
        // still full until the rear shrinks
        push_op(OP_INS_FRONT, 32'h6666_6666);
        push_op(OP_DEL_REAR, '0);
        push_op(OP_INS_FRONT, 32'hDEAD_BEEF);
        push_op(OP_INS_FRONT, 32'hC001_D00D);
        push_op(OP_INS_FRONT, 32'h7777_7777);
    endtask

    task automatic test_drain_to_empty();
        int k;
        for (k = 0; k < 6; k++) begin
            if (k % 2)
                push_op(OP_DEL_FRONT, $urandom);
            else
                push_op(OP_DEL_REAR, $urandom);
        end
        push_op(OP_INS_REAR, 32'h8000_0001);
        push_op(OP_DEL_FRONT, '0);
        push_op(OP_DEL_REAR, '0);
    endtask

    task automatic test_random_traffic();
        int weight [4];
        int sent;
        int run_len;
        int total;
        int pick;
        int k;
        lad_op_t op;
        logic [DATA_W-1:0] val;
        sent = 0;
        while (sent < RAND_ITEMS) begin
            run_len = $urandom_range(20, 60);
            total = 0;
            for (k = 0; k < 4; k++) begin
                weight[k] = $urandom_range(1, 10);
                total += weight[k];
            end
            // one long stretch with both sides always ready
            steady = (sent >= 500 && sent < 700);
            for (k = 0; k < run_len; k++) begin
                pick = $urandom_range(total - 1);
                if (pick < weight[0])
                    op = OP_INS_REAR;
                else if (pick < weight[0] + weight[1])
                    op = OP_INS_FRONT;
                else if (pick < weight[0] + weight[1] + weight[2])
                    op = OP_DEL_FRONT;
                else
                    op = OP_DEL_REAR;
                case ($urandom_range(9))
                    0: val = 32'h8000_0000;
                    1: val = 32'h7FFF_FFFF;
                    default: val = $urandom;
                endcase
                push_op(op, val);
            end
            sent += run_len;
        end
        steady = 1'b0;
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_empty_cases();
        test_fill_to_full();
        test_front_regrow();
        test_drain_to_empty();
        test_random_traffic();
        drain_results();
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/lad_pkg.sv
rtl/lad_ctrl.sv
rtl/lad_store.sv
rtl/linear_array_deque.sv
test/linear_array_deque_tb.sv
